@@ src/stbs_pkg.sv @@
// Shared constants, codes, control record and helpers for the sorted table search core.
package stbs_pkg;

    localparam int IDX_W = 10;
    localparam int KEY_IN_W = 32;
    localparam int MODE_W = 3;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_KEY_WIDTH = 32;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [MODE_W-1:0] MODE_EQ = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_GE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_GT = 3'd4;

    typedef struct packed {
        logic              op;
        logic [MODE_W-1:0] mode;
        logic              wr_ok;
        logic              done;
        logic              found;
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
        logic [IDX_W-1:0]  mid;
    } t_ctl;

    // The upper midpoint is used by the modes that keep the lower bound on a hit.
    function automatic logic [IDX_W-1:0] mid_of(
        input logic [IDX_W-1:0]  lo,
        input logic [IDX_W-1:0]  hi,
        input logic [MODE_W-1:0] mode
    );
        logic       up;
        logic [IDX_W:0] sum;
        up = (mode == MODE_LE) || (mode == MODE_LT);
        sum = {1'b0, lo} + {1'b0, hi} + {{IDX_W{1'b0}}, up};
        return sum[IDX_W:1];
    endfunction

endpackage

@@ src/stbs_if.sv @@
// Request and response channel interfaces of the sorted table search core.
interface stbs_in_if;
    import stbs_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic [MODE_W-1:0]          mode;
    logic [IDX_W-1:0]           entry_index;
    logic signed [KEY_IN_W-1:0] key;
    logic [IDX_W-1:0]           range_first;
    logic [IDX_W-1:0]           range_last;

    modport source (
        output valid, operation, mode, entry_index, key, range_first, range_last,
        input  ready
    );
    modport sink (
        input  valid, operation, mode, entry_index, key, range_first, range_last,
        output ready
    );
endinterface

interface stbs_out_if;
    import stbs_pkg::*;
    logic             valid;
    logic             ready;
    logic             found;
    logic [IDX_W-1:0] position;

    modport source (
        output valid, found, position,
        input  ready
    );
    modport sink (
        input  valid, found, position,
        output ready
    );
endinterface

@@ src/sorted_table_binary_search_core.sv @@
// Sorted key table with a pipelined binary search in five bound modes, one beat per cycle
// while the response is not stalled. A search beat passes through every halving step and
// then the response register. With N the smaller of TABLE_DEPTH and 1024, each of the
// $clog2(N) + 1 halving steps owns a full copy of the key table, and a load beat writes
// each copy as it passes that step, so loads and searches take effect strictly in beat
// order. Load beats give no response, and a beat is taken whenever the response register
// is free or drained, and never during reset.
module sorted_table_binary_search_core
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stbs_in_if.sink    i_req,
    stbs_out_if.source o_rsp
);

    localparam int RANGE_N = (TABLE_DEPTH < (1 << IDX_W)) ? TABLE_DEPTH : (1 << IDX_W);
    localparam int NSTEP = $clog2(RANGE_N) + 1;
    localparam logic [31:0] LAST_MAX = 32'(RANGE_N - 1);

    logic                        w_en;
    logic                        w_vld [NSTEP+1];
    t_ctl                        w_ctl [NSTEP+1];
    logic signed [KEY_WIDTH-1:0] w_key [NSTEP+1];
    logic [IDX_W-1:0]            w_last;

    logic             r_out_vld;
    logic             r_found;
    logic [IDX_W-1:0] r_pos;

    assign w_en = !r_out_vld || o_rsp.ready;
    assign i_req.ready = w_en && i_rst_n;

    assign w_last = (32'(i_req.range_last) > LAST_MAX) ? IDX_W'(LAST_MAX) : i_req.range_last;

    always_comb begin
        w_ctl[0] = '0;
        w_ctl[0].op = i_req.operation;
        w_ctl[0].mode = i_req.mode;
        w_ctl[0].wr_ok = 32'(i_req.entry_index) < 32'(TABLE_DEPTH);
        w_ctl[0].lo = i_req.range_first;
        w_ctl[0].hi = w_last;
        if (i_req.operation == OP_LOAD) begin
            w_ctl[0].mid = i_req.entry_index;
        end else begin
            w_ctl[0].mid = mid_of(i_req.range_first, w_last, i_req.mode);
            if ((i_req.range_first > w_last) || (i_req.mode > MODE_GT)) begin
                w_ctl[0].done = 1'b1;
            end
        end
    end

    assign w_vld[0] = i_req.valid && i_rst_n;
    assign w_key[0] = KEY_WIDTH'(i_req.key);

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        stbs_step #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .KEY_WIDTH   (KEY_WIDTH)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[k]),
            .i_ctl   (w_ctl[k]),
            .i_key   (w_key[k]),
            .o_vld   (w_vld[k+1]),
            .o_ctl   (w_ctl[k+1]),
            .o_key   (w_key[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_vld[NSTEP] && (w_ctl[NSTEP].op == OP_SEARCH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_found <= w_ctl[NSTEP].done && w_ctl[NSTEP].found;
            r_pos <= (w_ctl[NSTEP].done && w_ctl[NSTEP].found) ? w_ctl[NSTEP].lo : '0;
        end
    end

    assign o_rsp.valid = r_out_vld;
    assign o_rsp.found = r_found;
    assign o_rsp.position = r_pos;

    // A search must have settled by the time it leaves the last halving step.
    a_search_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[NSTEP] && (w_ctl[NSTEP].op == OP_SEARCH) |-> w_ctl[NSTEP].done)
        else $error("search left the last step unsettled");

    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.found |-> o_rsp.position == '0)
        else $error("miss reported with a nonzero position");

    a_hit_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.found |-> 32'(o_rsp.position) <= LAST_MAX)
        else $error("hit position beyond the searchable table");

    a_stall_holds_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_vld[NSTEP]) && $stable(w_ctl[NSTEP]))
        else $error("pipeline tail moved during a stall");

endmodule

@@ src/stbs_step.sv @@
// One halving step: a private copy of the key table, its registered read and the bound update.
module stbs_step
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  t_ctl                        i_ctl,
    input  logic signed [KEY_WIDTH-1:0] i_key,
    output logic                        o_vld,
    output t_ctl                        o_ctl,
    output logic signed [KEY_WIDTH-1:0] o_key
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];

    logic                        r_vld;
    t_ctl                        r_ctl;
    logic signed [KEY_WIDTH-1:0] r_key;
    logic signed [KEY_WIDTH-1:0] r_rd;

    logic w_lt;
    logic w_eq;
    logic w_gt;
    t_ctl n_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= i_ctl;
            r_key <= i_key;
        end
    end

    // Loads write this copy as they pass, so every search sees the table in beat order.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_vld && (i_ctl.op == OP_LOAD)) begin
                if (i_ctl.wr_ok) begin
                    mem[AW'(i_ctl.mid)] <= i_key;
                end
            end else begin
                r_rd <= mem[AW'(i_ctl.mid)];
            end
        end
    end

    assign w_lt = r_rd < r_key;
    assign w_eq = r_rd == r_key;
    assign w_gt = !w_lt && !w_eq;

    always_comb begin
        n_ctl = r_ctl;
        if ((r_ctl.op == OP_SEARCH) && !r_ctl.done) begin
            case (r_ctl.mode)
                MODE_EQ: begin
                    if (w_eq) begin
                        n_ctl.done = 1'b1;
                        n_ctl.found = 1'b1;
                        n_ctl.lo = r_ctl.mid;
                    end else if (w_lt) begin
                        if (r_ctl.mid == r_ctl.hi) begin
                            n_ctl.done = 1'b1;
                        end else begin
                            n_ctl.lo = r_ctl.mid + 1'b1;
                        end
                    end else begin
                        if (r_ctl.mid == r_ctl.lo) begin
                            n_ctl.done = 1'b1;
                        end else begin
                            n_ctl.hi = r_ctl.mid - 1'b1;
                        end
                    end
                end
                MODE_LE: begin
                    if (r_ctl.lo == r_ctl.hi) begin
                        n_ctl.done = 1'b1;
                        n_ctl.found = !w_gt;
                    end else if (!w_gt) begin
                        n_ctl.lo = r_ctl.mid;
                    end else begin
                        n_ctl.hi = r_ctl.mid - 1'b1;
                    end
                end
                MODE_GE: begin
                    if (r_ctl.lo == r_ctl.hi) begin
                        n_ctl.done = 1'b1;
                        n_ctl.found = !w_lt;
                    end else if (!w_lt) begin
                        n_ctl.hi = r_ctl.mid;
                    end else begin
                        n_ctl.lo = r_ctl.mid + 1'b1;
                    end
                end
                MODE_LT: begin
                    if (r_ctl.lo == r_ctl.hi) begin
                        n_ctl.done = 1'b1;
                        n_ctl.found = w_lt;
                    end else if (!w_lt) begin
                        n_ctl.hi = r_ctl.mid - 1'b1;
                    end else begin
                        n_ctl.lo = r_ctl.mid;
                    end
                end
                MODE_GT: begin
                    if (r_ctl.lo == r_ctl.hi) begin
                        n_ctl.done = 1'b1;
                        n_ctl.found = w_gt;
                    end else if (w_gt) begin
                        n_ctl.hi = r_ctl.mid;
                    end else begin
                        n_ctl.lo = r_ctl.mid + 1'b1;
                    end
                end
                default: begin
                    n_ctl.done = 1'b1;
                    n_ctl.found = 1'b0;
                end
            endcase
            n_ctl.mid = mid_of(n_ctl.lo, n_ctl.hi, n_ctl.mode);
        end
    end

    assign o_vld = r_vld;
    assign o_ctl = n_ctl;
    assign o_key = r_key;

endmodule
